@@ rtl/scratch_register_spill_allocator_assert.svh @@
// Assertion macros for the scratch register spill allocator.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SCRATCH_REGISTER_SPILL_ALLOCATOR_ASSERT_SVH
`define SCRATCH_REGISTER_SPILL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssa assertion failed");
// next-cycle implication
`define SSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssa assertion failed");
`else
`define SSA_ASSERT_NOW(lbl, ante, cons)
`define SSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/ssa_pkg.sv @@
// Shared types and constants for the scratch register spill allocator.
// No dependencies.
`timescale 1ns / 1ps
package ssa_pkg;

  localparam int DATA_POOL   = 3;
  localparam int ADDR_POOL   = 2;
  localparam int ALLOC_LIMIT = 30;
  localparam int AT_DEPTH    = ALLOC_LIMIT + 1;
  localparam int DEPTH_W     = 5;
  localparam int REG_W       = 3;
  localparam int DIDX_W      = (DATA_POOL > 1) ? $clog2(DATA_POOL) : 1;
  localparam int AIDX_W      = (ADDR_POOL > 1) ? $clog2(ADDR_POOL) : 1;

  typedef enum logic [2:0] {
    OP_RESET    = 3'd0,
    OP_ALLOC_D  = 3'd1,
    OP_ALLOC_A  = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_VALIDATE = 3'd4,
    OP_SPILLALL = 3'd5,
    OP_CHECK    = 3'd6,
    OP_QUERY    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    K_GRANT = 3'd0,
    K_SPILL = 3'd1,
    K_FILL  = 3'd2,
    K_DONE  = 3'd3,
    K_ERROR = 3'd4
  } kind_t;

  localparam logic [4:0] ERR_NONE         = 5'd0;
  localparam logic [4:0] ERR_DUP_SPILL    = 5'd1;
  localparam logic [4:0] ERR_STK_OVF      = 5'd2;
  localparam logic [4:0] ERR_STK_EMPTY    = 5'd3;
  localparam logic [4:0] ERR_STK_MISMATCH = 5'd4;
  localparam logic [4:0] ERR_FILL_BUSY    = 5'd5;
  localparam logic [4:0] ERR_CHK_DATA     = 5'd6;
  localparam logic [4:0] ERR_CHK_ADDR     = 5'd7;
  localparam logic [4:0] ERR_CHK_DCUR     = 5'd8;
  localparam logic [4:0] ERR_CHK_ACUR     = 5'd9;
  localparam logic [4:0] ERR_CHK_STACK    = 5'd10;
  localparam logic [4:0] ERR_CHK_COUNT    = 5'd11;
  localparam logic [4:0] ERR_TBL_OVF      = 5'd12;
  localparam logic [4:0] ERR_REL_OWNER    = 5'd13;
  localparam logic [4:0] ERR_REL_EMPTY    = 5'd14;
  localparam logic [4:0] ERR_REL_ORDER    = 5'd15;
  localparam logic [4:0] ERR_REL_SPILLED  = 5'd16;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_GRANT = 6'b000100,
    S_FILL  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_ERR   = 6'b100000
  } state_t;

  typedef struct packed {
    logic                 cls;
    logic [REG_W-1:0]     rnum;
    logic [DEPTH_W-1:0]   num;
  } spill_t;

  typedef struct packed {
    state_t step;
    logic   fire;
    logic   load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic halted;
    logic emit_req;
    logic alloc_busy;
    logic spill_bad;
    logic fill_go;
    logic scan_end;
    logic scan_skip;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/ssa_ctrl.sv @@
// Sequencer for the scratch register spill allocator.
// Depends on ssa_pkg; drives step commands into ssa_dp.
`timescale 1ns / 1ps
module ssa_ctrl import ssa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   fire;

  // a step that emits waits for room in the output register
  assign fire     = (state_r != S_IDLE) && (!st.emit_req || st.out_free);
  assign in_stall = (state_r != S_IDLE);

  assign cmd.step = state_r;
  assign cmd.fire = fire;
  assign cmd.load = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          if (st.op == OP_RESET || st.halted) begin
            state_nxt = S_IDLE;
          end else begin
            unique case (st.op)
              OP_ALLOC_D, OP_ALLOC_A: begin
                if (st.alloc_busy && st.spill_bad) state_nxt = S_ERR;
                else state_nxt = S_GRANT;
              end
              OP_VALIDATE: state_nxt = st.fill_go ? S_FILL : S_IDLE;
              OP_SPILLALL: state_nxt = S_SCAN;
              default:     state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_SCAN: begin
        if (fire) begin
          priority if (st.scan_end) state_nxt = S_IDLE;
          else if (st.scan_skip) state_nxt = S_SCAN;
          else if (st.spill_bad) state_nxt = S_ERR;
          else state_nxt = S_SCAN;
        end
      end
      S_GRANT, S_FILL, S_ERR: begin
        if (fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

@@ rtl/ssa_dp.sv @@
// Datapath of the scratch register spill allocator: owners, cursors, tables,
// spill stack memory and output register. Depends on ssa_pkg and the assert header.
`timescale 1ns / 1ps
`include "scratch_register_spill_allocator_assert.svh"
module ssa_dp import ssa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [2:0]         in_op,
  input  logic               in_reg_class,
  input  logic [REG_W-1:0]   in_reg_num,
  input  logic [DEPTH_W-1:0] in_alloc_depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic               out_class,
  output logic [REG_W-1:0]   out_reg,
  output logic [DEPTH_W-1:0] out_depth,
  output logic               out_free_ok,
  output logic [4:0]         out_error_code,
  output logic               out_last
);

  // latched item
  op_t                op_r;
  logic               cls_r;
  logic [REG_W-1:0]   reg_r;
  logic [DEPTH_W-1:0] depth_r;

  // allocator state
  logic [DATA_POOL-1:0] dbusy_r, dbusy_nxt;
  logic [DEPTH_W-1:0]   dnum_r [DATA_POOL];
  logic [DEPTH_W-1:0]   dnum_nxt [DATA_POOL];
  logic [ADDR_POOL-1:0] abusy_r, abusy_nxt;
  logic [DEPTH_W-1:0]   anum_r [ADDR_POOL];
  logic [DEPTH_W-1:0]   anum_nxt [ADDR_POOL];
  logic [DIDX_W-1:0]    dcur_r, dcur_nxt;
  logic [AIDX_W-1:0]    acur_r, acur_nxt;
  logic [AT_DEPTH-1:0]  pushed_r, pushed_nxt;
  logic                 tcls_r [AT_DEPTH];
  logic [REG_W-1:0]     treg_r [AT_DEPTH];
  logic [DEPTH_W-1:0]   count_r, count_nxt;
  logic [DEPTH_W-1:0]   ptr_r, ptr_nxt;
  logic [DEPTH_W-1:0]   idx_r, idx_nxt;
  logic                 halted_r, halted_nxt;
  logic [4:0]           latch_r, latch_nxt;
  logic [4:0]           pend_r, pend_nxt;

  spill_t stack_mem [AT_DEPTH];
  spill_t rd_q;
  spill_t mem_wdata;
  logic   mem_we, mem_re;
  logic   tbl_we;

  // output register
  logic               out_valid_r;
  kind_t              okind_r;
  logic               ocls_r, ofok_r, olast_r;
  logic [REG_W-1:0]   oreg_r;
  logic [DEPTH_W-1:0] odepth_r;
  logic [4:0]         oerr_r;

  // result of the current step
  logic               em_req, em_cls, em_fok, em_last;
  kind_t              em_kind;
  logic [REG_W-1:0]   em_reg;
  logic [DEPTH_W-1:0] em_depth;
  logic [4:0]         em_err;
  logic               emit;

  // derived
  logic               is_addr, a_busy, r_busy, reg_ok, fill_cond, spill_bad;
  logic [REG_W-1:0]   a_reg;
  logic [DEPTH_W-1:0] a_num, r_num;
  logic               s_cls;
  logic [REG_W-1:0]   s_reg;
  logic               out_free;

  assign is_addr = (op_r == OP_ALLOC_A);
  assign a_reg   = is_addr ? REG_W'(acur_r) : REG_W'(dcur_r);
  assign a_busy  = is_addr ? abusy_r[acur_r] : dbusy_r[dcur_r];
  assign a_num   = is_addr ? anum_r[acur_r] : dnum_r[dcur_r];
  assign reg_ok  = cls_r ? ({1'b0, reg_r} < 4'(ADDR_POOL)) : ({1'b0, reg_r} < 4'(DATA_POOL));
  assign r_busy  = cls_r ? abusy_r[reg_r[AIDX_W-1:0]] : dbusy_r[reg_r[DIDX_W-1:0]];
  assign r_num   = cls_r ? anum_r[reg_r[AIDX_W-1:0]] : dnum_r[reg_r[DIDX_W-1:0]];
  assign fill_cond = reg_ok && (depth_r <= DEPTH_W'(ALLOC_LIMIT)) && pushed_r[depth_r];
  assign s_cls   = tcls_r[idx_r];
  assign s_reg   = treg_r[idx_r];
  assign spill_bad = (cmd.step == S_SCAN) ? (ptr_r == DEPTH_W'(ALLOC_LIMIT))
                   : (pushed_r[a_num] || ptr_r == DEPTH_W'(ALLOC_LIMIT));
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cmd.fire && em_req;

  assign st.op         = op_r;
  assign st.halted     = halted_r;
  assign st.emit_req   = em_req;
  assign st.alloc_busy = a_busy;
  assign st.spill_bad  = spill_bad;
  assign st.fill_go    = fill_cond && (ptr_r != '0);
  assign st.scan_end   = (idx_r >= count_r);
  assign st.scan_skip  = pushed_r[idx_r];
  assign st.out_free   = out_free;

  // next state assuming the current step is taken; registers apply it on fire
  always_comb begin
    dbusy_nxt = dbusy_r;  dnum_nxt = dnum_r;
    abusy_nxt = abusy_r;  anum_nxt = anum_r;
    dcur_nxt  = dcur_r;   acur_nxt = acur_r;
    pushed_nxt = pushed_r;
    count_nxt = count_r;  ptr_nxt = ptr_r;  idx_nxt = idx_r;
    halted_nxt = halted_r; latch_nxt = latch_r; pend_nxt = pend_r;
    mem_we = 1'b0; mem_re = 1'b0; tbl_we = 1'b0;
    mem_wdata = '{cls: is_addr, rnum: a_reg, num: a_num};
    em_req = 1'b0; em_kind = K_DONE; em_cls = 1'b0; em_reg = '0; em_depth = '0;
    em_fok = 1'b0; em_err = ERR_NONE; em_last = 1'b1;

    unique case (cmd.step)
      S_EXEC: begin
        if (op_r == OP_RESET) begin
          em_req = 1'b1;
          dbusy_nxt = '0; abusy_nxt = '0; dcur_nxt = '0; acur_nxt = '0;
          pushed_nxt = '0; count_nxt = '0; ptr_nxt = '0;
          halted_nxt = 1'b0; latch_nxt = ERR_NONE;
        end else if (halted_r) begin
          em_req = 1'b1; em_kind = K_ERROR; em_err = latch_r;
        end else begin
          unique case (op_r)
            OP_ALLOC_D, OP_ALLOC_A: begin
              // spill the current owner before the grant
              if (a_busy) begin
                em_req = 1'b1; em_kind = K_SPILL; em_cls = is_addr;
                em_reg = a_reg; em_depth = a_num; em_last = 1'b0;
                mem_we = 1'b1;
                if (pushed_r[a_num]) begin
                  pend_nxt = ERR_DUP_SPILL;
                end else begin
                  pushed_nxt[a_num] = 1'b1;
                  ptr_nxt = ptr_r + 1'b1;
                  pend_nxt = ERR_STK_OVF;
                end
              end
            end
            OP_RELEASE: begin
              em_req = 1'b1;
              if (reg_ok) begin
                if (cls_r) begin
                  acur_nxt = (acur_r == '0) ? AIDX_W'(ADDR_POOL - 1) : acur_r - 1'b1;
                  abusy_nxt[reg_r[AIDX_W-1:0]] = 1'b0;
                end else begin
                  dcur_nxt = (dcur_r == '0) ? DIDX_W'(DATA_POOL - 1) : dcur_r - 1'b1;
                  dbusy_nxt[reg_r[DIDX_W-1:0]] = 1'b0;
                end
                if (count_r != '0) count_nxt = count_r - 1'b1;
                priority if (!r_busy || r_num != depth_r) begin
                  em_kind = K_ERROR; em_err = ERR_REL_OWNER;
                end else if (count_r == '0) begin
                  em_kind = K_ERROR; em_err = ERR_REL_EMPTY;
                end else if (count_r - 1'b1 != r_num) begin
                  em_kind = K_ERROR; em_err = ERR_REL_ORDER;
                end else if (pushed_r[r_num]) begin
                  em_kind = K_ERROR; em_err = ERR_REL_SPILLED;
                end else begin
                  em_kind = K_DONE;
                end
              end
            end
            OP_VALIDATE: begin
              if (fill_cond && ptr_r != '0) begin
                // pop: read the top entry into the registered read port
                ptr_nxt = ptr_r - 1'b1;
                mem_re = 1'b1;
              end else begin
                em_req = 1'b1;
                if (fill_cond) begin
                  em_kind = K_ERROR; em_err = ERR_STK_EMPTY;
                end
              end
            end
            OP_SPILLALL: idx_nxt = '0;
            OP_CHECK: begin
              em_req = 1'b1;
              priority if (|dbusy_r) begin
                em_kind = K_ERROR; em_err = ERR_CHK_DATA;
              end else if (|abusy_r) begin
                em_kind = K_ERROR; em_err = ERR_CHK_ADDR;
              end else if (dcur_r != '0) begin
                em_kind = K_ERROR; em_err = ERR_CHK_DCUR;
              end else if (acur_r != '0) begin
                em_kind = K_ERROR; em_err = ERR_CHK_ACUR;
              end else if (ptr_r != '0) begin
                em_kind = K_ERROR; em_err = ERR_CHK_STACK;
              end else if (count_r != '0) begin
                em_kind = K_ERROR; em_err = ERR_CHK_COUNT;
              end else begin
                em_kind = K_DONE;
              end
            end
            OP_QUERY: begin
              em_req = 1'b1; em_fok = !dbusy_r[dcur_r];
            end
            default: em_req = 1'b1;
          endcase
        end
      end
      S_GRANT: begin
        em_req = 1'b1;
        if (is_addr) begin
          abusy_nxt[acur_r] = 1'b1; anum_nxt[acur_r] = count_r;
          acur_nxt = (acur_r == AIDX_W'(ADDR_POOL - 1)) ? '0 : acur_r + 1'b1;
        end else begin
          dbusy_nxt[dcur_r] = 1'b1; dnum_nxt[dcur_r] = count_r;
          dcur_nxt = (dcur_r == DIDX_W'(DATA_POOL - 1)) ? '0 : dcur_r + 1'b1;
        end
        tbl_we = 1'b1;
        pushed_nxt[count_r] = 1'b0;
        count_nxt = count_r + 1'b1;
        if (count_r == DEPTH_W'(ALLOC_LIMIT)) begin
          em_kind = K_ERROR; em_err = ERR_TBL_OVF;
        end else begin
          em_kind = K_GRANT; em_cls = is_addr; em_reg = a_reg; em_depth = count_r;
        end
      end
      S_FILL: begin
        em_req = 1'b1;
        priority if (rd_q.num != depth_r) begin
          em_kind = K_ERROR; em_err = ERR_STK_MISMATCH;
        end else if (r_busy) begin
          em_kind = K_ERROR; em_err = ERR_FILL_BUSY;
        end else begin
          if (cls_r) begin
            abusy_nxt[reg_r[AIDX_W-1:0]] = 1'b1; anum_nxt[reg_r[AIDX_W-1:0]] = depth_r;
          end else begin
            dbusy_nxt[reg_r[DIDX_W-1:0]] = 1'b1; dnum_nxt[reg_r[DIDX_W-1:0]] = depth_r;
          end
          pushed_nxt[depth_r] = 1'b0;
          em_kind = K_FILL; em_cls = cls_r; em_reg = reg_r; em_depth = depth_r;
        end
      end
      S_SCAN: begin
        if (idx_r >= count_r) begin
          em_req = 1'b1;
        end else if (pushed_r[idx_r]) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          em_req = 1'b1; em_kind = K_SPILL; em_cls = s_cls; em_reg = s_reg;
          em_depth = idx_r; em_last = 1'b0;
          mem_we = 1'b1;
          mem_wdata = '{cls: s_cls, rnum: s_reg, num: idx_r};
          pushed_nxt[idx_r] = 1'b1;
          ptr_nxt = ptr_r + 1'b1;
          pend_nxt = ERR_STK_OVF;
          if (s_cls) abusy_nxt[s_reg[AIDX_W-1:0]] = 1'b0;
          else dbusy_nxt[s_reg[DIDX_W-1:0]] = 1'b0;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_ERR: begin
        em_req = 1'b1; em_kind = K_ERROR; em_err = pend_r;
      end
      default: ;
    endcase

    // any error result halts the block and latches its code
    if (em_req && em_kind == K_ERROR) begin
      halted_nxt = 1'b1;
      latch_nxt  = em_err;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= '0; abusy_r <= '0; dcur_r <= '0; acur_r <= '0;
      pushed_r <= '0; count_r <= '0; ptr_r <= '0; idx_r <= '0;
      halted_r <= 1'b0; latch_r <= ERR_NONE; pend_r <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fire) begin
        dbusy_r <= dbusy_nxt; abusy_r <= abusy_nxt;
        dcur_r <= dcur_nxt; acur_r <= acur_nxt;
        pushed_r <= pushed_nxt; count_r <= count_nxt; ptr_r <= ptr_nxt;
        idx_r <= idx_nxt; halted_r <= halted_nxt; latch_r <= latch_nxt;
        pend_r <= pend_nxt;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload: item latch, owner numbers, table, output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_op); cls_r <= in_reg_class;
      reg_r <= in_reg_num; depth_r <= in_alloc_depth;
    end
    if (cmd.fire) begin
      dnum_r <= dnum_nxt; anum_r <= anum_nxt;
    end
    if (cmd.fire && tbl_we) begin
      tcls_r[count_r] <= is_addr;
      treg_r[count_r] <= a_reg;
    end
    if (emit) begin
      okind_r <= em_kind; ocls_r <= em_cls; oreg_r <= em_reg; odepth_r <= em_depth;
      ofok_r <= em_fok; oerr_r <= em_err; olast_r <= em_last;
    end
  end

  // spill stack memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.fire && mem_we) stack_mem[ptr_r] <= mem_wdata;
    if (cmd.fire && mem_re) rd_q <= stack_mem[ptr_r - 1'b1];
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = okind_r;
  assign out_class      = ocls_r;
  assign out_reg        = oreg_r;
  assign out_depth      = odepth_r;
  assign out_free_ok    = ofok_r;
  assign out_error_code = oerr_r;
  assign out_last       = olast_r;

  `SSA_ASSERT_NOW(a_no_overwrite, emit, !out_valid_r || !out_stall)
  `SSA_ASSERT_NEXT(a_err_halts, emit && em_kind == K_ERROR, halted_r)
  `SSA_ASSERT_NEXT(a_reset_clears, emit && cmd.step == S_EXEC && op_r == OP_RESET,
                   count_r == '0 && ptr_r == '0 && !halted_r)

endmodule

@@ rtl/scratch_register_spill_allocator.sv @@
// Steps from the accepted item to the result register: release, check, query, reset, halted
// answers and validate without a fill answer from exec; alloc emits its spill, when needed,
// from exec, then its grant or error; validate with a fill pops in exec and answers from the
// fill step; spill-all walks the table one entry per cycle while the output is not stalled.
// One item in flight; the next is taken the cycle after the last result is registered, and a
// stalled output holds any step that emits. Reset: synchronous rst_n clears control state.
`timescale 1ns / 1ps
module scratch_register_spill_allocator import ssa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel: one register reference per item
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic               in_reg_class,
  input  logic [REG_W-1:0]   in_reg_num,
  input  logic [DEPTH_W-1:0] in_alloc_depth,
  // result channel: one or more items per input item, last marks the final one
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic               out_class,
  output logic [REG_W-1:0]   out_reg,
  output logic [DEPTH_W-1:0] out_depth,
  output logic               out_free_ok,
  output logic [4:0]         out_error_code,
  output logic               out_last
);

  cmd_t  cmd;
  stat_t st;

  // sequencer: steps through exec, grant, fill, table scan and error states
  ssa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: owner tables, cursors, allocation table, spill stack, output register
  ssa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_op          (in_op),
    .in_reg_class   (in_reg_class),
    .in_reg_num     (in_reg_num),
    .in_alloc_depth (in_alloc_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_class      (out_class),
    .out_reg        (out_reg),
    .out_depth      (out_depth),
    .out_free_ok    (out_free_ok),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule

@@ tb/sv/ssa_checker.sv @@
// Predictor and result checker for the scratch register spill allocator.
// Depends on ssa_pkg for op, kind and error codes; watches both channels of the block.
`timescale 1ns / 1ps
module ssa_checker import ssa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic               in_reg_class,
  input  logic [REG_W-1:0]   in_reg_num,
  input  logic [DEPTH_W-1:0] in_alloc_depth,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_kind,
  input  logic               out_class,
  input  logic [REG_W-1:0]   out_reg,
  input  logic [DEPTH_W-1:0] out_depth,
  input  logic               out_free_ok,
  input  logic [4:0]         out_error_code,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  typedef struct {
    logic [2:0] kind;
    logic       cls;
    logic [2:0] rnum;
    logic [4:0] depth;
    logic       fok;
    logic [4:0] err;
    logic       last;
  } grant_rec_t;

  grant_rec_t awaited_q[$];
  grant_rec_t item_q[$];

  // allocator image
  bit  d_busy[DATA_POOL];
  int  d_num[DATA_POOL];
  bit  a_busy[ADDR_POOL];
  int  a_num[ADDR_POOL];
  int  d_cur, a_cur;
  int  tbl_cls[AT_DEPTH];
  int  tbl_reg[AT_DEPTH];
  bit  tbl_pushed[AT_DEPTH];
  int  live_cnt;
  int  stk_num[AT_DEPTH];
  int  stk_ptr;
  bit  stopped;
  int  err_code;

  function automatic void clear_image();
    for (int i = 0; i < DATA_POOL; i++) begin d_busy[i] = 0; d_num[i] = 0; end
    for (int i = 0; i < ADDR_POOL; i++) begin a_busy[i] = 0; a_num[i] = 0; end
    for (int i = 0; i < AT_DEPTH; i++) begin
      tbl_cls[i] = 0; tbl_reg[i] = 0; tbl_pushed[i] = 0; stk_num[i] = 0;
    end
    d_cur = 0; a_cur = 0; live_cnt = 0; stk_ptr = 0; stopped = 0; err_code = 0;
  endfunction

  function automatic void put(kind_t k, int c, int r, int d, int f, int e);
    grant_rec_t g;
    if (item_q.size() >= 32) return;
    g.kind = k; g.cls = c[0]; g.rnum = r[2:0]; g.depth = d[4:0];
    g.fok = f[0]; g.err = e[4:0]; g.last = 0;
    item_q.push_back(g);
  endfunction

  function automatic bit halt(int code);
    stopped = 1;
    err_code = code;
    put(K_ERROR, 0, 0, 0, 0, code);
    return 0;
  endfunction

  function automatic bit owner_busy(int c, int r);
    return c ? a_busy[r % ADDR_POOL] : d_busy[r % DATA_POOL];
  endfunction

  function automatic int owner_num(int c, int r);
    return c ? a_num[r % ADDR_POOL] : d_num[r % DATA_POOL];
  endfunction

  function automatic void set_owner(int c, int r, bit b, int n);
    if (c) begin a_busy[r % ADDR_POOL] = b; a_num[r % ADDR_POOL] = n; end
    else begin d_busy[r % DATA_POOL] = b; d_num[r % DATA_POOL] = n; end
  endfunction

  function automatic bit push_spill(int c, int r, int n);
    n = n % AT_DEPTH;
    stk_num[stk_ptr % AT_DEPTH] = n;
    put(K_SPILL, c, r, n, 0, 0);
    if (tbl_pushed[n]) return halt(ERR_DUP_SPILL);
    tbl_pushed[n] = 1;
    stk_ptr++;
    if (stk_ptr > ALLOC_LIMIT) return halt(ERR_STK_OVF);
    return 1;
  endfunction

  function automatic void pop_fill(int c, int r, int n);
    if (stk_ptr == 0) begin void'(halt(ERR_STK_EMPTY)); return; end
    stk_ptr--;
    if (stk_num[stk_ptr % AT_DEPTH] != n) begin void'(halt(ERR_STK_MISMATCH)); return; end
    if (owner_busy(c, r)) begin void'(halt(ERR_FILL_BUSY)); return; end
    set_owner(c, r, 1, n);
    put(K_FILL, c, r, n, 0, 0);
    tbl_pushed[n % AT_DEPTH] = 0;
  endfunction

  function automatic void take_reg(int c);
    int pool, r, n;
    pool = c ? ADDR_POOL : DATA_POOL;
    r = (c ? a_cur : d_cur) % pool;
    n = live_cnt;
    if (owner_busy(c, r) && !push_spill(c, r, owner_num(c, r))) return;
    set_owner(c, r, 1, n);
    tbl_cls[n % AT_DEPTH] = c; tbl_reg[n % AT_DEPTH] = r; tbl_pushed[n % AT_DEPTH] = 0;
    if (c) a_cur = (r + 1 == pool) ? 0 : r + 1;
    else d_cur = (r + 1 == pool) ? 0 : r + 1;
    if (live_cnt == ALLOC_LIMIT) begin live_cnt++; void'(halt(ERR_TBL_OVF)); return; end
    live_cnt++;
    put(K_GRANT, c, r, n, 0, 0);
  endfunction

  function automatic void give_back(int c, int r, int d);
    int pool, cur, n;
    bit had;
    pool = c ? ADDR_POOL : DATA_POOL;
    if (r >= pool) begin put(K_DONE, 0, 0, 0, 0, 0); return; end
    cur = c ? a_cur : d_cur;
    cur = (cur % pool == 0) ? pool - 1 : cur % pool - 1;
    if (c) a_cur = cur; else d_cur = cur;
    had = owner_busy(c, r);
    n = owner_num(c, r);
    set_owner(c, r, 0, n);
    if (!had || n != d) begin void'(halt(ERR_REL_OWNER)); return; end
    if (live_cnt == 0) begin void'(halt(ERR_REL_EMPTY)); return; end
    live_cnt--;
    if (live_cnt != n) begin void'(halt(ERR_REL_ORDER)); return; end
    if (tbl_pushed[n % AT_DEPTH]) begin void'(halt(ERR_REL_SPILLED)); return; end
    put(K_DONE, 0, 0, 0, 0, 0);
  endfunction

  function automatic void flush_all();
    for (int i = 0; i < live_cnt && i <= ALLOC_LIMIT; i++) begin
      if (!tbl_pushed[i]) begin
        if (!push_spill(tbl_cls[i], tbl_reg[i], i)) return;
        set_owner(tbl_cls[i], tbl_reg[i], 0, owner_num(tbl_cls[i], tbl_reg[i]));
      end
    end
    put(K_DONE, 0, 0, 0, 0, 0);
  endfunction

  function automatic void audit();
    for (int i = 0; i < DATA_POOL; i++)
      if (d_busy[i]) begin void'(halt(ERR_CHK_DATA)); return; end
    for (int i = 0; i < ADDR_POOL; i++)
      if (a_busy[i]) begin void'(halt(ERR_CHK_ADDR)); return; end
    if (d_cur != 0) begin void'(halt(ERR_CHK_DCUR)); return; end
    if (a_cur != 0) begin void'(halt(ERR_CHK_ACUR)); return; end
    if (stk_ptr != 0) begin void'(halt(ERR_CHK_STACK)); return; end
    if (live_cnt != 0) begin void'(halt(ERR_CHK_COUNT)); return; end
    put(K_DONE, 0, 0, 0, 0, 0);
  endfunction

  function automatic void predict_grants(op_t op, int c, int r, int d);
    int pool;
    pool = c ? ADDR_POOL : DATA_POOL;
    item_q.delete();
    if (op == OP_RESET) begin
      clear_image();
      put(K_DONE, 0, 0, 0, 0, 0);
    end else if (stopped) begin
      put(K_ERROR, 0, 0, 0, 0, err_code);
    end else begin
      case (op)
        OP_ALLOC_D:  take_reg(0);
        OP_ALLOC_A:  take_reg(1);
        OP_RELEASE:  give_back(c, r, d);
        OP_VALIDATE: begin
          if (r < pool && d <= ALLOC_LIMIT && tbl_pushed[d]) pop_fill(c, r, d);
          else put(K_DONE, 0, 0, 0, 0, 0);
        end
        OP_SPILLALL: flush_all();
        OP_CHECK:    audit();
        default:     put(K_DONE, 0, 0, 0, d_busy[d_cur % DATA_POOL] ? 0 : 1, 0);
      endcase
    end
    if (item_q.size() > 0) item_q[item_q.size() - 1].last = 1;
    foreach (item_q[i]) awaited_q.push_back(item_q[i]);
  endfunction

  assign pending = awaited_q.size();

  always @(posedge clk) begin
    grant_rec_t w;
    if (!rst_n) begin
      clear_image();
      awaited_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      // drain before predicting so a result can never meet its own item's prediction early
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (awaited_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t unexpected result kind=%0d", $realtime, out_kind);
          fail_count <= fail_count + 1;
        end else begin
          w = awaited_q.pop_front();
          if (out_kind !== w.kind || out_class !== w.cls || out_reg !== w.rnum ||
              out_depth !== w.depth || out_free_ok !== w.fok ||
              out_error_code !== w.err || out_last !== w.last) begin
            if (fail_count < 10)
              $display("%0t mismatch exp k%0d c%0d r%0d d%0d f%0d e%0d l%0d got k%0d c%0d r%0d d%0d f%0d e%0d l%0d",
                       $realtime, w.kind, w.cls, w.rnum, w.depth, w.fok, w.err, w.last,
                       out_kind, out_class, out_reg, out_depth, out_free_ok,
                       out_error_code, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_grants(op_t'(in_op), in_reg_class, in_reg_num, in_alloc_depth);
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the scratch register spill allocator testbench: clock, reset, stimulus, verdict.
// Depends on ssa_pkg, the block itself and ssa_checker.
`timescale 1ns / 1ps
module testbench;
  import ssa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 300;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [2:0]         in_op = 0;
  logic               in_reg_class = 0;
  logic [REG_W-1:0]   in_reg_num = 0;
  logic [DEPTH_W-1:0] in_alloc_depth = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [2:0]         out_kind;
  logic               out_class;
  logic [REG_W-1:0]   out_reg;
  logic [DEPTH_W-1:0] out_depth;
  logic               out_free_ok;
  logic [4:0]         out_error_code;
  logic               out_last;

  int fail_count, pending, checked;
  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // generator's own view of the live allocations, newest at the back
  int  live_cls[$];
  int  live_reg[$];
  int  live_num[$];
  bit  live_spilled[$];
  int  d_holder[DATA_POOL];
  int  a_holder[ADDR_POOL];
  int  gen_dcur, gen_acur;

  always #1 clk = ~clk;

  scratch_register_spill_allocator dut (.*);

  ssa_checker chk (.*);

  // receiver: stall at the rate of the current phase
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog: count cycles where neither channel moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("[scratch_register_spill_allocator] ERROR");
        $finish;
      end
    end
  end

  // choose the idling mix from how far the stimulus has got
  function automatic void pick_phase();
    case ((items_sent * 4) / (RANDOM_ITEMS + 40))
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 49; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 49; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endfunction

  // hand one item to the block and hold it until it is taken
  task automatic send_item(op_t op, int c, int r, int d);
    pick_phase();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid       <= 1;
    in_op          <= op;
    in_reg_class   <= c[0];
    in_reg_num     <= r[2:0];
    in_alloc_depth <= d[4:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(op_t'($urandom_range(7)), $urandom_range(1), $urandom_range(7),
              $urandom_range(31));
  endtask

  task automatic start_session();
    live_cls.delete(); live_reg.delete(); live_num.delete(); live_spilled.delete();
    foreach (d_holder[i]) d_holder[i] = -1;
    foreach (a_holder[i]) a_holder[i] = -1;
    gen_dcur = 0;
    gen_acur = 0;
    send_item(OP_RESET, $urandom_range(1), $urandom_range(7), $urandom_range(31));
  endtask

  // allocate and track which older allocation gets spilled by the wrap
  task automatic grab(int c);
    int r, idx;
    idx = live_num.size();
    r = c ? gen_acur : gen_dcur;
    if (c) begin
      if (a_holder[r] >= 0) live_spilled[a_holder[r]] = 1;
      a_holder[r] = idx;
      gen_acur = (r + 1) % ADDR_POOL;
    end else begin
      if (d_holder[r] >= 0) live_spilled[d_holder[r]] = 1;
      d_holder[r] = idx;
      gen_dcur = (r + 1) % DATA_POOL;
    end
    live_cls.push_back(c); live_reg.push_back(r);
    live_num.push_back(idx); live_spilled.push_back(0);
    send_item(c ? OP_ALLOC_A : OP_ALLOC_D, $urandom_range(1), $urandom_range(7),
              $urandom_range(31));
  endtask

  // release the newest allocation, filling it back first when it was spilled
  task automatic drop_newest();
    int c, r, n, idx;
    idx = live_num.size() - 1;
    c = live_cls[idx]; r = live_reg[idx]; n = live_num[idx];
    if (live_spilled[idx]) send_item(OP_VALIDATE, c, r, n);
    send_item(OP_RELEASE, c, r, n);
    if (c) begin
      a_holder[r] = -1;
      gen_acur = (gen_acur == 0) ? ADDR_POOL - 1 : gen_acur - 1;
    end else begin
      d_holder[r] = -1;
      gen_dcur = (gen_dcur == 0) ? DATA_POOL - 1 : gen_dcur - 1;
    end
    void'(live_cls.pop_back()); void'(live_reg.pop_back());
    void'(live_num.pop_back()); void'(live_spilled.pop_back());
  endtask

  task automatic spill_everything();
    foreach (live_spilled[i]) live_spilled[i] = 1;
    foreach (d_holder[i]) d_holder[i] = -1;
    foreach (a_holder[i]) a_holder[i] = -1;
    send_item(OP_SPILLALL, 0, 0, 0);
  endtask

  initial begin
    int pick, ops, directed;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: wrap with spill, query both ways, spill-all and refill, halting errors
    start_session();
    send_item(OP_QUERY, 0, 0, 0);
    grab(0); grab(0); grab(0);
    send_item(OP_QUERY, 0, 0, 0);
    grab(0);
    grab(1); grab(1); grab(1);
    spill_everything();
    send_item(OP_VALIDATE, 1, 7, 31);
    send_item(OP_RELEASE, 0, 7, 0);
    drop_newest(); drop_newest();
    send_item(OP_CHECK, 0, 0, 0);
    send_item(OP_ALLOC_D, 0, 0, 0);
    start_session();
    send_item(OP_RELEASE, 1, 1, 31);
    send_item(OP_VALIDATE, 0, 0, 0);
    start_session();
    send_item(OP_CHECK, 0, 0, 0);
    directed = items_sent;

    // random sessions of well-formed alloc/release traffic with some noise
    while (items_sent < directed + RANDOM_ITEMS) begin
      start_session();
      if ($urandom_range(19) == 0) begin
        // run the table past its limit
        repeat (ALLOC_LIMIT + 1) send_item(OP_ALLOC_D, 0, 0, 0);
        send_noise();
        continue;
      end
      ops = $urandom_range(4, 20);
      repeat (ops) begin
        pick = $urandom_range(99);
        if (pick < 30 && live_num.size() < 10) grab(0);
        else if (pick < 50 && live_num.size() < 10) grab(1);
        else if (pick < 75 && live_num.size() > 0) drop_newest();
        else if (pick < 80) spill_everything();
        else if (pick < 90) send_item(OP_QUERY, $urandom_range(1), $urandom_range(7),
                                      $urandom_range(31));
        else send_noise();
      end
      while (live_num.size() > 0) drop_newest();
      send_item(OP_CHECK, 0, 0, 0);
    end
    in_valid <= 0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d items (%0d directed), checked %0d results over four idling phases",
             items_sent, directed, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[scratch_register_spill_allocator] OK");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending);
      $display("[scratch_register_spill_allocator] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ssa_pkg.sv
rtl/ssa_ctrl.sv
rtl/ssa_dp.sv
rtl/scratch_register_spill_allocator.sv
tb/sv/ssa_checker.sv
tb/sv/testbench.sv
